>>> design/three_finger_tap_press_detector_macros.svh
// ----------------------------------------------------------------------------
// three_finger_tap_press_detector_macros
// assertion macros shared by the detector modules
// ----------------------------------------------------------------------------
`ifndef THREE_FINGER_TAP_PRESS_DETECTOR_MACROS_SVH
`define THREE_FINGER_TAP_PRESS_DETECTOR_MACROS_SVH

// property that holds in the same cycle
`define TFP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// consequent that holds in the cycle after the antecedent
`define TFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/tfp_pkg.sv
// ----------------------------------------------------------------------------
// tfp_pkg
// shared types and constants of the three-finger tap and press detector
// ----------------------------------------------------------------------------
`default_nettype none

package tfp_pkg;

	localparam int TIME_WIDTH_DEF = 32;
	localparam int POS_WIDTH_DEF  = 16;

	localparam int COUNT_W    = 4;
	localparam int TAP_W      = 32;
	localparam int PRESS_W    = 32;
	localparam int MOVE_W     = 33;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_ADDR_W = 5;
	localparam int REG_IDX_W  = 2;

	localparam logic [REG_IDX_W-1:0] REG_TAP_TIME   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_PRESS_TIME = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MOVE_LIMIT = 2'd2;

	localparam logic [TAP_W-1:0]   TAP_TIME_RESET   = 32'd300000;
	localparam logic [PRESS_W-1:0] PRESS_TIME_RESET = 32'd350000;
	localparam logic [MOVE_W-1:0]  MOVE_LIMIT_RESET = 33'd42949673;

	localparam logic [COUNT_W-1:0] GESTURE_FINGERS = 4'd3;
	localparam logic [COUNT_W-1:0] NO_FINGERS      = 4'd0;

	localparam logic GESTURE_TAP   = 1'b0;
	localparam logic GESTURE_PRESS = 1'b1;

	typedef struct packed {
		logic [TAP_W-1:0]   tap_time_limit;
		logic [PRESS_W-1:0] press_time_threshold;
		logic [MOVE_W-1:0]  move_limit_squared;
	} cfg_t;

	typedef struct packed {
		logic hit;
		logic gesture;
	} res_t;

endpackage

`default_nettype wire

>>> design/tfp_regs.sv
// ----------------------------------------------------------------------------
// tfp_regs
// apb register file holding the timing and movement limits
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_regs (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [tfp_pkg::CFG_ADDR_W-1:0]   paddr,
	input  wire logic [tfp_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic      [tfp_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                                  pready,
	output tfp_pkg::cfg_t                         cfg
);

	logic [tfp_pkg::REG_IDX_W-1:0] idx;
	logic                          wr_en;
	tfp_pkg::cfg_t                 cfg_q;

	assign idx    = paddr[tfp_pkg::CFG_ADDR_W-1:3];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_time_limit       <= tfp_pkg::TAP_TIME_RESET;
			cfg_q.press_time_threshold <= tfp_pkg::PRESS_TIME_RESET;
			cfg_q.move_limit_squared   <= tfp_pkg::MOVE_LIMIT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				tfp_pkg::REG_TAP_TIME: begin
					cfg_q.tap_time_limit <= pwdata[tfp_pkg::TAP_W-1:0];
				end
				tfp_pkg::REG_PRESS_TIME: begin
					cfg_q.press_time_threshold <= pwdata[tfp_pkg::PRESS_W-1:0];
				end
				tfp_pkg::REG_MOVE_LIMIT: begin
					cfg_q.move_limit_squared <= pwdata[tfp_pkg::MOVE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			tfp_pkg::REG_TAP_TIME:   prdata = tfp_pkg::CFG_DATA_W'(cfg_q.tap_time_limit);
			tfp_pkg::REG_PRESS_TIME: prdata = tfp_pkg::CFG_DATA_W'(cfg_q.press_time_threshold);
			tfp_pkg::REG_MOVE_LIMIT: prdata = tfp_pkg::CFG_DATA_W'(cfg_q.move_limit_squared);
			default:                 prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> design/tfp_centroid.sv
// ----------------------------------------------------------------------------
// tfp_centroid
// one centroid coordinate, floor of the sum of three positions over three
// ----------------------------------------------------------------------------
`default_nettype none

module tfp_centroid #(
	parameter int POS_WIDTH = tfp_pkg::POS_WIDTH_DEF
) (
	input  wire logic [POS_WIDTH-1:0] pos_a,
	input  wire logic [POS_WIDTH-1:0] pos_b,
	input  wire logic [POS_WIDTH-1:0] pos_c,
	output logic      [POS_WIDTH-1:0] centroid
);

	localparam int SUM_W    = POS_WIDTH + 2;
	localparam int RECIP_SH = SUM_W + 2;
	localparam int PROD_W   = SUM_W + RECIP_SH;
	localparam logic [RECIP_SH-1:0] RECIP =
		RECIP_SH'(((64'd1 << RECIP_SH) + 64'd2) / 64'd3);

	logic [SUM_W-1:0]  sum;
	logic [PROD_W-1:0] prod;
	logic [SUM_W-1:0]  quot;

	// reciprocal rounded up, exact over the whole sum range
	assign sum      = SUM_W'(pos_a) + SUM_W'(pos_b) + SUM_W'(pos_c);
	assign prod     = PROD_W'(sum) * PROD_W'(RECIP);
	assign quot     = prod[PROD_W-1:RECIP_SH];
	assign centroid = quot[POS_WIDTH-1:0];

endmodule

`default_nettype wire

>>> design/tfp_gesture.sv
// ----------------------------------------------------------------------------
// tfp_gesture
// gesture state and the tap and press decision for one frame
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_finger_tap_press_detector_macros.svh"

module tfp_gesture #(
	parameter int TIME_WIDTH = tfp_pkg::TIME_WIDTH_DEF,
	parameter int POS_WIDTH  = tfp_pkg::POS_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic [tfp_pkg::COUNT_W-1:0] count_s1,
	input  wire logic [TIME_WIDTH-1:0]       time_s1,
	input  wire logic [POS_WIDTH-1:0]        cx_s1,
	input  wire logic [POS_WIDTH-1:0]        cy_s1,
	input  wire tfp_pkg::cfg_t               cfg,
	output tfp_pkg::res_t                    res
);

	localparam int DIST_W = 2 * POS_WIDTH + 1;
	localparam int LIM_W  = (DIST_W > tfp_pkg::MOVE_W) ? DIST_W : tfp_pkg::MOVE_W;
	localparam int EL_W   = (TIME_WIDTH > tfp_pkg::TAP_W) ? TIME_WIDTH : tfp_pkg::TAP_W;

	logic                    active_q, moved_q, press_q, tap_q;
	logic                    active_d, moved_d, press_d, tap_d;
	logic [TIME_WIDTH-1:0]   start_time_q;
	logic [POS_WIDTH-1:0]    start_cx_q, start_cy_q;
	logic                    latch_start;
	logic [POS_WIDTH-1:0]    dx, dy;
	logic [2*POS_WIDTH-1:0]  sq_x, sq_y;
	logic [DIST_W-1:0]       shift_sq;
	logic                    moved_now;
	logic [TIME_WIDTH-1:0]   elapsed;
	logic                    press_due, tap_short;
	logic                    three, many;

	assign three = (count_s1 == tfp_pkg::GESTURE_FINGERS);
	assign many  = (count_s1 > tfp_pkg::GESTURE_FINGERS);

	assign dx       = (cx_s1 >= start_cx_q) ? (cx_s1 - start_cx_q) : (start_cx_q - cx_s1);
	assign dy       = (cy_s1 >= start_cy_q) ? (cy_s1 - start_cy_q) : (start_cy_q - cy_s1);
	assign sq_x     = (2*POS_WIDTH)'(dx) * (2*POS_WIDTH)'(dx);
	assign sq_y     = (2*POS_WIDTH)'(dy) * (2*POS_WIDTH)'(dy);
	assign shift_sq = DIST_W'(sq_x) + DIST_W'(sq_y);

	assign moved_now = LIM_W'(shift_sq) > LIM_W'(cfg.move_limit_squared);

	// wraps modulo the timestamp width
	assign elapsed   = time_s1 - start_time_q;
	assign press_due = EL_W'(elapsed) >= EL_W'(cfg.press_time_threshold);
	assign tap_short = EL_W'(elapsed) <= EL_W'(cfg.tap_time_limit);

	always_comb begin
		active_d    = active_q;
		moved_d     = moved_q;
		press_d     = press_q;
		tap_d       = tap_q;
		latch_start = 1'b0;
		res.hit     = 1'b0;
		res.gesture = tfp_pkg::GESTURE_TAP;
		priority if (three) begin
			if (!active_q) begin
				active_d    = 1'b1;
				moved_d     = 1'b0;
				press_d     = 1'b0;
				tap_d       = 1'b0;
				latch_start = 1'b1;
			end else begin
				moved_d = moved_q | moved_now;
				if (!press_q && !moved_d && press_due) begin
					press_d     = 1'b1;
					res.hit     = 1'b1;
					res.gesture = tfp_pkg::GESTURE_PRESS;
				end
			end
		end else if (many) begin
			active_d = 1'b0;
			moved_d  = 1'b0;
			press_d  = 1'b0;
			tap_d    = 1'b0;
		end else if (active_q) begin
			if (!tap_q && !press_q && !moved_q && tap_short) begin
				tap_d       = 1'b1;
				res.hit     = 1'b1;
				res.gesture = tfp_pkg::GESTURE_TAP;
			end
			if (count_s1 == tfp_pkg::NO_FINGERS) begin
				active_d = 1'b0;
				moved_d  = 1'b0;
				press_d  = 1'b0;
				tap_d    = 1'b0;
			end
		end else begin
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			moved_q  <= 1'b0;
			press_q  <= 1'b0;
			tap_q    <= 1'b0;
		end else if (advance) begin
			active_q <= active_d;
			moved_q  <= moved_d;
			press_q  <= press_d;
			tap_q    <= tap_d;
		end
	end

	// start values are read only while a gesture is active
	always_ff @(posedge clk) begin
		if (advance && latch_start) begin
			start_time_q <= time_s1;
			start_cx_q   <= cx_s1;
			start_cy_q   <= cy_s1;
		end
	end

	`TFP_ASSERT(a_hit_needs_active, !res.hit || active_q, "result without an active gesture")
	`TFP_ASSERT_NEXT(a_press_marked, advance && res.hit && res.gesture == tfp_pkg::GESTURE_PRESS,
		press_q, "press sent but not recorded")
	`TFP_ASSERT_NEXT(a_many_clears, advance && many, !active_q && !moved_q && !press_q && !tap_q,
		"too many fingers did not clear the gesture")

endmodule

`default_nettype wire

>>> design/three_finger_tap_press_detector.sv
// ----------------------------------------------------------------------------
// three_finger_tap_press_detector
// recognises three-finger taps and presses from a stream of touch frames
// ----------------------------------------------------------------------------
// one touch frame is a transfer on the in channel (in_valid/in_ready): finger
// count, timestamp and three finger positions. a recognised gesture is a
// transfer on the out channel (out_valid/out_ready), gesture 0 tap, 1 press;
// a frame gives at most one result and most give none.
// the frame centroid is formed before the input register; the decision and
// the state update run between the input register and the output register.
// throughput: one frame per cycle, set by the single decision stage, while
// the out channel does not stall. a stalled out channel holds the result;
// one more frame waits in the input register and in_ready falls until the
// result is taken. reset clears the gesture state and both stages and loads
// the default limits; the apb port (pready always high) reads and writes the
// limits at byte addresses 0, 8 and 16. the user must write it only while no
// frame is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_finger_tap_press_detector_macros.svh"

module three_finger_tap_press_detector #(
	parameter int TIME_WIDTH = tfp_pkg::TIME_WIDTH_DEF,
	parameter int POS_WIDTH  = tfp_pkg::POS_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [tfp_pkg::COUNT_W-1:0]    finger_count,
	input  wire logic [TIME_WIDTH-1:0]          time_us,
	input  wire logic [POS_WIDTH-1:0]           first_x,
	input  wire logic [POS_WIDTH-1:0]           first_y,
	input  wire logic [POS_WIDTH-1:0]           second_x,
	input  wire logic [POS_WIDTH-1:0]           second_y,
	input  wire logic [POS_WIDTH-1:0]           third_x,
	input  wire logic [POS_WIDTH-1:0]           third_y,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic                                gesture,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [tfp_pkg::CFG_ADDR_W-1:0] paddr,
	input  wire logic [tfp_pkg::CFG_DATA_W-1:0] pwdata,
	output logic      [tfp_pkg::CFG_DATA_W-1:0] prdata,
	output logic                                pready
);

	tfp_pkg::cfg_t                 cfg;
	tfp_pkg::res_t                 res;
	logic [POS_WIDTH-1:0]          cx, cy;
	logic                          valid_s1;
	logic [tfp_pkg::COUNT_W-1:0]   count_s1;
	logic [TIME_WIDTH-1:0]         time_s1;
	logic [POS_WIDTH-1:0]          cx_s1, cy_s1;
	logic                          valid_s2;
	logic                          gesture_s2;
	logic                          advance;
	logic                          in_xfer;

	tfp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tfp_centroid #(.POS_WIDTH(POS_WIDTH)) u_cent_x (
		.pos_a    (first_x),
		.pos_b    (second_x),
		.pos_c    (third_x),
		.centroid (cx)
	);

	tfp_centroid #(.POS_WIDTH(POS_WIDTH)) u_cent_y (
		.pos_a    (first_y),
		.pos_b    (second_y),
		.pos_c    (third_y),
		.centroid (cy)
	);

	assign advance  = valid_s1 & (~valid_s2 | out_ready);
	assign in_ready = ~valid_s1 | advance;
	assign in_xfer  = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			count_s1 <= finger_count;
			time_s1  <= time_us;
			cx_s1    <= cx;
			cy_s1    <= cy;
		end
	end

	tfp_gesture #(.TIME_WIDTH(TIME_WIDTH), .POS_WIDTH(POS_WIDTH)) u_gesture (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.count_s1 (count_s1),
		.time_s1  (time_s1),
		.cx_s1    (cx_s1),
		.cy_s1    (cy_s1),
		.cfg      (cfg),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.hit;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.hit) begin
			gesture_s2 <= res.gesture;
		end
	end

	assign out_valid = valid_s2;
	assign gesture   = gesture_s2;

	`TFP_ASSERT_NEXT(a_frame_held, valid_s1 && !advance, valid_s1, "waiting frame lost")
	`TFP_ASSERT_NEXT(a_result_loaded, advance && res.hit, valid_s2, "result not presented")

endmodule

`default_nettype wire

>>> bench/tb_three_finger_tap_press_detector.sv
// ----------------------------------------------------------------------------
// tb_three_finger_tap_press_detector
// self-checking bench for the three-finger tap and press detector
// ----------------------------------------------------------------------------
// touch frames go in over a valid/ready channel. a gesture tracker in the
// bench follows each accepted frame and queues the tap or press it expects.
// every result transfer is checked against the oldest queued gesture.
// the bench runs a directed sequence, then movement and time boundaries under
// several limit settings, then a long receiver hold-off, then random gestures
// under several sender and receiver idling mixes.
// ----------------------------------------------------------------------------
module tb_three_finger_tap_press_detector;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [2:0][tfp_pkg::POS_WIDTH_DEF-1:0] coords_t;

	typedef struct packed {
		logic [tfp_pkg::COUNT_W-1:0]        count;
		logic [tfp_pkg::TIME_WIDTH_DEF-1:0] stamp;
		coords_t                            px;
		coords_t                            py;
	} touch_frame_t;

	localparam logic [tfp_pkg::MOVE_W-1:0] MOVE_LIMIT_TOP = 33'd8589672450;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           in_valid     = 1'b0;
	logic                           in_ready;
	logic [tfp_pkg::COUNT_W-1:0]    finger_count = '0;
	logic [31:0]                    time_us      = '0;
	logic [15:0]                    first_x      = '0;
	logic [15:0]                    first_y      = '0;
	logic [15:0]                    second_x     = '0;
	logic [15:0]                    second_y     = '0;
	logic [15:0]                    third_x      = '0;
	logic [15:0]                    third_y      = '0;
	logic                           out_valid;
	logic                           out_ready    = 1'b0;
	logic                           gesture;
	logic                           psel         = 1'b0;
	logic                           penable      = 1'b0;
	logic                           pwrite       = 1'b0;
	logic [tfp_pkg::CFG_ADDR_W-1:0] paddr        = '0;
	logic [tfp_pkg::CFG_DATA_W-1:0] pwdata       = '0;
	logic [tfp_pkg::CFG_DATA_W-1:0] prdata;
	logic                           pready;

	// bench copy of the limits and the gesture state
	tfp_pkg::cfg_t limits = '{tfp_pkg::TAP_TIME_RESET, tfp_pkg::PRESS_TIME_RESET,
		tfp_pkg::MOVE_LIMIT_RESET};
	logic        gest_active;
	logic        gest_moved;
	logic        press_done;
	logic        tap_done;
	logic [31:0] gest_t0;
	logic [15:0] gest_cx0;
	logic [15:0] gest_cy0;

	logic pending_gestures[$];
	int   error_count   = 0;
	int   frames_sent   = 0;
	int   idle_pct      = 0;
	int   stall_pct     = 0;
	int   hold_request  = 0;
	int   hold_left     = 0;

	three_finger_tap_press_detector dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.finger_count (finger_count),
		.time_us      (time_us),
		.first_x      (first_x),
		.first_y      (first_y),
		.second_x     (second_x),
		.second_y     (second_y),
		.third_x      (third_x),
		.third_y      (third_y),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.gesture      (gesture),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	always #6 clk = ~clk;

	function automatic void drop_gesture();
		gest_active = 1'b0;
		gest_moved  = 1'b0;
		press_done  = 1'b0;
		tap_done    = 1'b0;
		gest_t0     = '0;
		gest_cx0    = '0;
		gest_cy0    = '0;
	endfunction

	// follows one accepted frame, returns 1 when it yields a gesture
	function automatic logic track_gesture(input touch_frame_t f, output logic g);
		logic [17:0] sx, sy;
		logic [15:0] cx, cy, dx, dy;
		logic [32:0] shift_sq;
		logic [31:0] elapsed;
		logic        emitted;
		emitted = 1'b0;
		g       = tfp_pkg::GESTURE_TAP;
		elapsed = f.stamp - gest_t0;
		if (f.count == tfp_pkg::GESTURE_FINGERS) begin
			sx = 18'(f.px[0]) + 18'(f.px[1]) + 18'(f.px[2]);
			sy = 18'(f.py[0]) + 18'(f.py[1]) + 18'(f.py[2]);
			cx = 16'(sx / 3);
			cy = 16'(sy / 3);
			if (!gest_active) begin
				gest_active = 1'b1;
				gest_moved  = 1'b0;
				press_done  = 1'b0;
				tap_done    = 1'b0;
				gest_t0     = f.stamp;
				gest_cx0    = cx;
				gest_cy0    = cy;
			end else begin
				dx = (cx >= gest_cx0) ? cx - gest_cx0 : gest_cx0 - cx;
				dy = (cy >= gest_cy0) ? cy - gest_cy0 : gest_cy0 - cy;
				shift_sq = 33'(dx) * 33'(dx) + 33'(dy) * 33'(dy);
				if (shift_sq > limits.move_limit_squared)
					gest_moved = 1'b1;
				if (!press_done && !gest_moved && elapsed >= limits.press_time_threshold) begin
					press_done = 1'b1;
					g          = tfp_pkg::GESTURE_PRESS;
					emitted    = 1'b1;
				end
			end
		end else if (f.count > tfp_pkg::GESTURE_FINGERS) begin
			drop_gesture();
		end else if (gest_active) begin
			if (!tap_done && !press_done && !gest_moved && elapsed <= limits.tap_time_limit) begin
				tap_done = 1'b1;
				g        = tfp_pkg::GESTURE_TAP;
				emitted  = 1'b1;
			end
			if (f.count == tfp_pkg::NO_FINGERS)
				drop_gesture();
		end
		return emitted;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		$display("%0t ns mismatch: %s, expected %0d got %0d", $time, what, want, got);
		error_count++;
	endtask

	always @(posedge clk) begin : check_results
		logic want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_gestures.size() == 0) begin
				report_mismatch("gesture with none pending", 'x, 64'(gesture));
			end else begin
				want = pending_gestures.pop_front();
				if (gesture !== want)
					report_mismatch("gesture", 64'(want), 64'(gesture));
			end
		end
	end

	always @(negedge clk) begin
		if (hold_left == 0 && hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_frame(input touch_frame_t f);
		logic g;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		finger_count <= f.count;
		time_us      <= f.stamp;
		first_x      <= f.px[0];
		first_y      <= f.py[0];
		second_x     <= f.px[1];
		second_y     <= f.py[1];
		third_x      <= f.px[2];
		third_y      <= f.py[2];
		do @(posedge clk); while (!in_ready);
		if (track_gesture(f, g))
			pending_gestures.push_back(g);
		frames_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_gestures.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [tfp_pkg::REG_IDX_W-1:0] idx,
			input logic [63:0] value);
		logic [tfp_pkg::CFG_DATA_W-1:0] want;
		want = '0;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			tfp_pkg::REG_TAP_TIME: begin
				limits.tap_time_limit = value[tfp_pkg::TAP_W-1:0];
				want = 64'(limits.tap_time_limit);
			end
			tfp_pkg::REG_PRESS_TIME: begin
				limits.press_time_threshold = value[tfp_pkg::PRESS_W-1:0];
				want = 64'(limits.press_time_threshold);
			end
			tfp_pkg::REG_MOVE_LIMIT: begin
				limits.move_limit_squared = value[tfp_pkg::MOVE_W-1:0];
				want = 64'(limits.move_limit_squared);
			end
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// address still selects the register just written
		if (prdata !== want)
			report_mismatch("register read-back", want, prdata);
	endtask

	task automatic apply_limits(input logic [31:0] tap, input logic [31:0] press,
			input logic [32:0] move);
		wait_drained();
		write_limit(tfp_pkg::REG_TAP_TIME, 64'(tap));
		write_limit(tfp_pkg::REG_PRESS_TIME, 64'(press));
		write_limit(tfp_pkg::REG_MOVE_LIMIT, 64'(move));
	endtask

	function automatic logic [15:0] nudge(input logic [15:0] v, input int span);
		int s;
		if (span < 0)
			return 16'($urandom);
		s = int'(v) + int'($urandom_range(0, 2 * span)) - span;
		if (s < 0)
			s = 0;
		else if (s > 65535)
			s = 65535;
		return 16'(s);
	endfunction

	function automatic touch_frame_t make_frame(input logic [3:0] count,
			input logic [31:0] stamp, input coords_t bx, input coords_t by, input int span);
		touch_frame_t f;
		f.count = count;
		f.stamp = stamp;
		for (int i = 0; i < 3; i++) begin
			f.px[i] = nudge(bx[i], span);
			f.py[i] = nudge(by[i], span);
		end
		return f;
	endfunction

	// offsets from the gesture start that straddle both time limits
	function automatic logic [31:0] pick_offset();
		case ($urandom_range(4))
			0: return $urandom_range(0, 64);
			1: return limits.tap_time_limit + 32'($urandom_range(0, 2)) - 32'd1;
			2: return limits.press_time_threshold + 32'($urandom_range(0, 2)) - 32'd1;
			3: return $urandom_range(0, limits.press_time_threshold);
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_span();
		case ($urandom_range(3))
			0: return 0;
			1: return 3;
			2: return 8000;
			default: return -1;
		endcase
	endfunction

	task automatic run_gestures(input int frame_budget);
		coords_t     bx, by;
		logic [31:0] t0;
		int          stop_at;
		stop_at = frames_sent + frame_budget;
		while (frames_sent < stop_at) begin
			for (int i = 0; i < 3; i++) begin
				bx[i] = 16'($urandom);
				by[i] = 16'($urandom);
			end
			t0 = $urandom;
			if ($urandom_range(7) == 0) begin
				// stray frame
				send_frame(make_frame(4'($urandom_range(15)), $urandom, bx, by, 0));
				continue;
			end
			send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, t0, bx, by, 0));
			repeat ($urandom_range(4))
				send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, t0 + pick_offset(), bx, by,
					pick_span()));
			case ($urandom_range(3))
				0: send_frame(make_frame(tfp_pkg::NO_FINGERS, t0 + pick_offset(), bx, by, -1));
				1: begin
					send_frame(make_frame(4'($urandom_range(1, 2)), t0 + pick_offset(),
						bx, by, -1));
					if ($urandom_range(1))
						send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, t0 + pick_offset(),
							bx, by, pick_span()));
					send_frame(make_frame(tfp_pkg::NO_FINGERS, t0 + pick_offset(), bx, by,
						-1));
				end
				2: send_frame(make_frame(4'($urandom_range(4, 15)), t0 + pick_offset(),
					bx, by, -1));
				default: begin
					send_frame(make_frame(4'($urandom_range(1, 2)), t0 + pick_offset(),
						bx, by, -1));
					send_frame(make_frame(tfp_pkg::NO_FINGERS, t0 + pick_offset(), bx, by,
						-1));
				end
			endcase
		end
	endtask

	task automatic test_directed();
		coords_t zero_c, full_c, mid_x, mid_y;
		zero_c = '0;
		full_c = '1;
		mid_x  = {16'd1, 16'd1, 16'd0};
		mid_y  = {16'h8000, 16'h7fff, 16'h1234};
		// no gesture yet
		send_frame(make_frame(tfp_pkg::NO_FINGERS, 32'd0, zero_c, zero_c, 0));
		send_frame(make_frame(4'd2, 32'd5, full_c, full_c, 0));
		// full-scale move spoils the gesture
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd100, zero_c, zero_c, 0));
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd101, full_c, full_c, 0));
		send_frame(make_frame(4'd1, 32'd102, zero_c, zero_c, 0));
		send_frame(make_frame(tfp_pkg::NO_FINGERS, 32'd103, zero_c, zero_c, 0));
		// wrapping timestamp, tap on lift to two, then a press while back at three
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'hffff_ff00, mid_x, mid_y, 0));
		send_frame(make_frame(4'd2, 32'h0000_0100, zero_c, zero_c, 0));
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'h0000_0200, mid_x, mid_y, 0));
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'hffff_ff00 + 32'd350000,
			mid_x, mid_y, 0));
		send_frame(make_frame(4'd1, 32'd400000, zero_c, zero_c, 0));
		send_frame(make_frame(tfp_pkg::NO_FINGERS, 32'd400001, zero_c, zero_c, 0));
		// tap time exactly at and one past the limit
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd1000, zero_c, zero_c, 0));
		send_frame(make_frame(tfp_pkg::NO_FINGERS, 32'd301000, zero_c, zero_c, 0));
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd5000, zero_c, zero_c, 0));
		send_frame(make_frame(tfp_pkg::NO_FINGERS, 32'd305001, zero_c, zero_c, 0));
		// press one short of and exactly at the threshold
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd10, full_c, full_c, 0));
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd350009, full_c, full_c, 0));
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd350010, full_c, full_c, 0));
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd400000, full_c, full_c, 0));
		// too many fingers clears everything
		send_frame(make_frame(4'd15, 32'd400001, full_c, full_c, 0));
		send_frame(make_frame(4'd4, 32'd400002, zero_c, zero_c, 0));
		send_frame(make_frame(4'd1, 32'd400003, zero_c, zero_c, 0));
		wait_drained();
	endtask

	task automatic test_limit_sweep();
		coords_t base_c, shift_x, shift_y, far_x, far_y;
		base_c  = {3{16'd1000}};
		shift_x = {3{16'd1003}};
		shift_y = {3{16'd1004}};
		far_x   = {3{16'd1005}};
		far_y   = {3{16'd1001}};
		apply_limits('0, '0, '0);
		run_gestures(25);
		apply_limits('1, '1, MOVE_LIMIT_TOP);
		run_gestures(25);
		apply_limits(32'd40, 32'd60, 33'd25);
		// shift of exactly the limit still counts as still
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd0, base_c, base_c, 0));
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd60, shift_x, shift_y, 0));
		send_frame(make_frame(tfp_pkg::NO_FINGERS, 32'd70, base_c, base_c, 0));
		// one unit past it spoils the gesture for good
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd0, base_c, base_c, 0));
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd30, far_x, far_y, 0));
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd60, base_c, base_c, 0));
		send_frame(make_frame(4'd1, 32'd61, base_c, base_c, 0));
		send_frame(make_frame(tfp_pkg::NO_FINGERS, 32'd62, base_c, base_c, 0));
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd0, base_c, base_c, 0));
		send_frame(make_frame(tfp_pkg::NO_FINGERS, 32'd40, base_c, base_c, 0));
		send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, 32'd0, base_c, base_c, 0));
		send_frame(make_frame(tfp_pkg::NO_FINGERS, 32'd41, base_c, base_c, 0));
		run_gestures(25);
		repeat (2) begin
			apply_limits($urandom_range(0, 600000), $urandom_range(0, 700000),
				MOVE_LIMIT_TOP >> $urandom_range(0, 32));
			run_gestures(25);
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		coords_t bx, by;
		logic [31:0] t0;
		apply_limits(tfp_pkg::TAP_TIME_RESET, tfp_pkg::PRESS_TIME_RESET,
			tfp_pkg::MOVE_LIMIT_RESET);
		idle_pct     = 0;
		stall_pct    = 0;
		hold_request = 400;
		repeat (2) begin
			repeat (8) begin
				for (int i = 0; i < 3; i++) begin
					bx[i] = 16'($urandom);
					by[i] = 16'($urandom);
				end
				t0 = $urandom;
				send_frame(make_frame(tfp_pkg::GESTURE_FINGERS, t0, bx, by, 0));
				send_frame(make_frame(4'd1, t0 + 32'd10, bx, by, 0));
				send_frame(make_frame(tfp_pkg::NO_FINGERS, t0 + 32'd20, bx, by, 0));
			end
			// sender holds back until every gesture is out
			wait_drained();
		end
	endtask

	task automatic test_idle_mix();
		int idle_set[4]  = '{0, 74, 0, 18};
		int stall_set[4] = '{0, 0, 74, 18};
		for (int k = 0; k < 4; k++) begin
			if (k == 0)
				apply_limits(tfp_pkg::TAP_TIME_RESET, tfp_pkg::PRESS_TIME_RESET,
					tfp_pkg::MOVE_LIMIT_RESET);
			else
				apply_limits($urandom_range(0, 500000), $urandom_range(0, 600000),
					33'($urandom_range(0, 100000000)));
			idle_pct  = idle_set[k];
			stall_pct = stall_set[k];
			run_gestures(60);
		end
		wait_drained();
	endtask

	initial begin
		drop_gesture();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_limit_sweep();
		test_backpressure();
		test_idle_mix();
		wait_drained();
		if (error_count == 0)
			$display("tb_three_finger_tap_press_detector: clean");
		else
			$display("tb_three_finger_tap_press_detector: errors");
		$finish;
	end

	initial begin
		#2_400_000;
		$display("tb_three_finger_tap_press_detector: errors");
		$finish;
	end

endmodule
